[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PLU_AST_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plu assertion failed");

// next-cycle implication
`define PLU_AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plu assertion failed");

`endif

[rtl/plu_pkg.sv]
package plu_pkg;

  localparam logic [31:0] TIME_STEP_RST = 32'd65536;

  typedef struct packed {
    logic               kind;
    logic               is_wall;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic [30:0]        energy;
    logic signed [31:0] energy_rate;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] half_vel_x;
    logic signed [31:0] half_vel_y;
    logic [30:0]        new_energy;
    logic [30:0]        half_energy;
    logic [30:0]        sound_speed;
    logic               updated;
  } out_t;

endpackage

[rtl/plu_kick.sv]
module plu_kick (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic [31:0]     time_step,
  input  logic            in_valid,
  input  plu_pkg::in_t    in_data,
  output logic            out_valid,
  output plu_pkg::out_t   out_data
);

  function automatic logic signed [49:0] add_sh(input logic signed [31:0] v,
                                                input logic signed [63:0] p,
                                                input logic half);
    logic signed [63:0] sh;
    sh = half ? (p >>> 17) : (p >>> 16);
    return 50'(v) + 50'(sh);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    logic signed [49:0] mx;
    logic signed [49:0] mn;
    mx = 50'sd2147483647;
    mn = -mx - 50'sd1;
    if (x > mx) return 32'sh7FFFFFFF;
    else if (x < mn) return 32'sh80000000;
    else return x[31:0];
  endfunction

  function automatic logic [30:0] clampe(input logic signed [49:0] x);
    if (x < 0) return '0;
    else if (x > 50'sd2147483647) return 31'h7FFFFFFF;
    else return x[30:0];
  endfunction

  // stage 1: rate products
  logic               v1_r;
  plu_pkg::in_t       d1_r;
  logic signed [63:0] pax_r, pay_r, pe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r  <= in_data;
      pax_r <= 64'($signed(in_data.acc_x) * $signed({1'b0, time_step}));
      pay_r <= 64'($signed(in_data.acc_y) * $signed({1'b0, time_step}));
      pe_r  <= 64'($signed(in_data.energy_rate) * $signed({1'b0, time_step}));
    end
  end

  // stage 2: kicks
  logic          v2_r, pred2_r;
  plu_pkg::out_t d2_r, d2_nxt;
  logic          pred2_nxt;
  logic signed [31:0] e1;

  always_comb begin
    e1        = $signed({1'b0, d1_r.energy});
    pred2_nxt = !d1_r.kind && !d1_r.is_wall;
    d2_nxt = '{new_pos_x: d1_r.pos_x, new_pos_y: d1_r.pos_y,
               new_vel_x: d1_r.vel_x, new_vel_y: d1_r.vel_y,
               half_vel_x: d1_r.vel_x, half_vel_y: d1_r.vel_y,
               new_energy: d1_r.energy, half_energy: d1_r.energy,
               sound_speed: '0, updated: !d1_r.is_wall};
    if (!d1_r.is_wall) begin
      d2_nxt.new_vel_x  = sat32(add_sh(d1_r.vel_x, pax_r, d1_r.kind));
      d2_nxt.new_vel_y  = sat32(add_sh(d1_r.vel_y, pay_r, d1_r.kind));
      d2_nxt.new_energy = clampe(add_sh(e1, pe_r, d1_r.kind));
      if (!d1_r.kind) begin
        d2_nxt.half_vel_x  = sat32(add_sh(d1_r.vel_x, pax_r, 1'b1));
        d2_nxt.half_vel_y  = sat32(add_sh(d1_r.vel_y, pay_r, 1'b1));
        d2_nxt.half_energy = clampe(add_sh(e1, pe_r, 1'b1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_r    <= d2_nxt;
      pred2_r <= pred2_nxt;
    end
  end

  // stage 3: drift products
  logic               v3_r, pred3_r;
  plu_pkg::out_t      d3_r;
  logic signed [63:0] phx_r, phy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d3_r    <= d2_r;
      pred3_r <= pred2_r;
      phx_r   <= 64'($signed(d2_r.half_vel_x) * $signed({1'b0, time_step}));
      phy_r   <= 64'($signed(d2_r.half_vel_y) * $signed({1'b0, time_step}));
    end
  end

  // stage 4: drift
  logic          v4_r;
  plu_pkg::out_t d4_r, d4_nxt;

  always_comb begin
    d4_nxt = d3_r;
    if (pred3_r) begin
      d4_nxt.new_pos_x = sat32(add_sh(d3_r.new_pos_x, phx_r, 1'b0));
      d4_nxt.new_pos_y = sat32(add_sh(d3_r.new_pos_y, phy_r, 1'b0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d4_r <= d4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = d4_r;

endmodule

[rtl/plu_sqrt.sv]
module plu_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  plu_pkg::out_t   in_data,
  output logic            out_valid,
  output plu_pkg::out_t   out_data
);

  localparam int NS = 13;
  localparam logic [25:0] DIV3_MUL = 26'd44739243;

  typedef struct packed {
    logic [51:0] rad;
    logic [27:0] rem;
    logic [25:0] root;
  } sq_t;

  function automatic sq_t sq_step(input sq_t s);
    sq_t         n;
    logic [28:0] r;
    logic [28:0] t;
    r = {s.rem[26:0], s.rad[51:50]};
    t = {1'b0, s.root, 2'b01};
    n.rad = {s.rad[49:0], 2'b00};
    if (r >= t) begin
      r = r - t;
      n.root = {s.root[24:0], 1'b1};
    end else begin
      n.root = {s.root[24:0], 1'b0};
    end
    n.rem = r[27:0];
    return n;
  endfunction

  sq_t           sq_in  [NS];
  sq_t           sq_r   [NS];
  plu_pkg::out_t res_in [NS];
  plu_pkg::out_t res_r  [NS];
  logic [NS-1:0] v_in, v_r;
  logic [34:0]   e10;

  assign e10 = 35'(in_data.new_energy) * 35'd10;

  for (genvar j = 0; j < NS; j++) begin : g_st
    if (j == 0) begin : g_first
      assign sq_in[j]  = '{rad: {1'b0, e10, 16'h0000}, rem: '0, root: '0};
      assign res_in[j] = in_data;
      assign v_in[j]   = in_valid;
    end else begin : g_next
      assign sq_in[j]  = sq_r[j-1];
      assign res_in[j] = res_r[j-1];
      assign v_in[j]   = v_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (adv) begin
        v_r[j] <= v_in[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[j]  <= sq_step(sq_step(sq_in[j]));
        res_r[j] <= res_in[j];
      end
    end
  end

  // divide root by 3
  logic          vo_r;
  plu_pkg::out_t do_r, do_nxt;
  logic [51:0]   prod;

  always_comb begin
    prod   = 52'(sq_r[NS-1].root) * 52'(DIV3_MUL);
    do_nxt = res_r[NS-1];
    do_nxt.sound_speed = res_r[NS-1].updated ? 31'(prod[51:27]) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (adv) begin
      vo_r <= v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      do_r <= do_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = do_r;

endmodule

[rtl/planar_leapfrog_particle_update.sv]
// Throughput: one word per cycle; the whole pipeline holds when the
// result register is full and not taken.
// Sound speed comes from a 13-stage square root, two root bits per stage.
// Reset clears all valid bits and loads time_step with 1.0.
module planar_leapfrog_particle_update (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_wdata,
  input  logic            in_valid,
  output logic            in_ready,
  input  plu_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output plu_pkg::out_t   out_data
);

  logic [31:0]   time_step_r;
  logic          adv;
  logic          k_valid;
  plu_pkg::out_t k_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= plu_pkg::TIME_STEP_RST;
    end else if (cfg_we) begin
      time_step_r <= cfg_wdata;
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  plu_kick u_kick (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .time_step (time_step_r),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (k_valid),
    .out_data  (k_data)
  );

  plu_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (k_valid),
    .in_data   (k_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[rtl/plu_chk.sv]
`include "assert_macros.svh"

module plu_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input plu_pkg::out_t   out_data
);

  logic wall_w;

  assign wall_w = out_valid && !out_data.updated;

  `PLU_AST_NOW(a_ready, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready))
  `PLU_AST_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `PLU_AST_NOW(a_wall_snd, clk, rst_n, wall_w, out_data.sound_speed == 31'd0)
  `PLU_AST_NOW(a_wall_vecho, clk, rst_n, wall_w, out_data.new_vel_x == out_data.half_vel_x)
  `PLU_AST_NOW(a_wall_eecho, clk, rst_n, wall_w, out_data.new_energy == out_data.half_energy)

endmodule

bind planar_leapfrog_particle_update plu_chk u_plu_chk (.*);

[test/tb_planar_leapfrog_particle_update.sv]
`timescale 1ns / 100ps

module tb_planar_leapfrog_particle_update;

  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_CORRECT = 1'b1;
  localparam int   LATENCY      = 18;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_we = 1'b0;
  logic  [31:0] cfg_wdata = '0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  plu_pkg::in_t  in_data = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  plu_pkg::out_t out_data;

  logic [31:0]   dt_q = plu_pkg::TIME_STEP_RST;
  plu_pkg::out_t pending_q[$];
  int            n_err = 0;
  int            n_sent = 0;
  int            n_got = 0;
  int            src_idle_pct = 0;
  int            sink_stall_pct = 0;

  planar_leapfrog_particle_update DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic signed [63:0] step_inc(logic signed [31:0] r, int k);
    logic signed [95:0] p;
    p = $signed({{64{r[31]}}, r}) * $signed({64'd0, dt_q});
    p = p >>> k;
    return p[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  function automatic logic [30:0] clamp_e(logic signed [63:0] x);
    if (x < 0) return '0;
    if (x > 64'sd2147483647) return 31'h7fffffff;
    return x[30:0];
  endfunction

  function automatic logic [30:0] root_floor(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[30:0];
  endfunction

  function automatic plu_pkg::out_t advance_particle(plu_pkg::in_t p);
    plu_pkg::out_t o;
    logic signed [63:0] e;
    e = {33'd0, p.energy};
    o.new_pos_x = p.pos_x;
    o.new_pos_y = p.pos_y;
    o.new_vel_x = p.vel_x;
    o.new_vel_y = p.vel_y;
    o.half_vel_x = p.vel_x;
    o.half_vel_y = p.vel_y;
    o.new_energy = p.energy;
    o.half_energy = p.energy;
    o.sound_speed = '0;
    o.updated = !p.is_wall;
    if (!p.is_wall) begin
      if (p.kind == KIND_PREDICT) begin
        o.half_vel_x = sat32(p.vel_x + step_inc(p.acc_x, 17));
        o.half_vel_y = sat32(p.vel_y + step_inc(p.acc_y, 17));
        o.half_energy = clamp_e(e + step_inc(p.energy_rate, 17));
        o.new_pos_x = sat32(p.pos_x + step_inc(o.half_vel_x, 16));
        o.new_pos_y = sat32(p.pos_y + step_inc(o.half_vel_y, 16));
        o.new_vel_x = sat32(p.vel_x + step_inc(p.acc_x, 16));
        o.new_vel_y = sat32(p.vel_y + step_inc(p.acc_y, 16));
        o.new_energy = clamp_e(e + step_inc(p.energy_rate, 16));
      end else begin
        o.new_vel_x = sat32(p.vel_x + step_inc(p.acc_x, 17));
        o.new_vel_y = sat32(p.vel_y + step_inc(p.acc_y, 17));
        o.new_energy = clamp_e(e + step_inc(p.energy_rate, 17));
      end
      o.sound_speed = root_floor((({33'd0, o.new_energy}) << 16) * 10 / 9);
    end
    return o;
  endfunction

  // sink: random stall, check each accepted word
  always @(posedge clk) begin
    plu_pkg::out_t exp_w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_got++;
        if (pending_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected word %h", out_data);
        end else begin
          exp_w = pending_q.pop_front();
          if (out_data !== exp_w) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: exp pos %h %h vel %h %h hv %h %h e %h he %h c %h u %b",
                exp_w.new_pos_x, exp_w.new_pos_y, exp_w.new_vel_x, exp_w.new_vel_y,
                exp_w.half_vel_x, exp_w.half_vel_y, exp_w.new_energy,
                exp_w.half_energy, exp_w.sound_speed, exp_w.updated);
            if (n_err <= 10)
              $display("          got pos %h %h vel %h %h hv %h %h e %h he %h c %h u %b",
                out_data.new_pos_x, out_data.new_pos_y, out_data.new_vel_x,
                out_data.new_vel_y, out_data.half_vel_x, out_data.half_vel_y,
                out_data.new_energy, out_data.half_energy, out_data.sound_speed,
                out_data.updated);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_particle(plu_pkg::in_t p);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(advance_particle(p));
    n_sent++;
  endtask

  task automatic drain_and_set_dt(logic [31:0] dt);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= dt;
    @(posedge clk);
    cfg_we <= 1'b0;
    dt_q = dt;
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(255) - 128;
      3: return ($urandom_range(65535) << 8) - 32'h00800000;
      default: return $urandom();
    endcase
  endfunction

  function automatic plu_pkg::in_t rnd_particle();
    plu_pkg::in_t p;
    p.kind = 1'($urandom_range(1));
    p.is_wall = ($urandom_range(9) == 0);
    p.pos_x = rnd_val();
    p.pos_y = rnd_val();
    p.vel_x = rnd_val();
    p.vel_y = rnd_val();
    p.acc_x = rnd_val();
    p.acc_y = rnd_val();
    p.energy = ($urandom_range(3) == 0) ? 31'($urandom_range(70000)) : 31'(rnd_val());
    p.energy_rate = rnd_val();
    return p;
  endfunction

  task automatic test_directed();
    plu_pkg::in_t p;
    logic [31:0] ext[4];
    ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    for (int i = 0; i < 16; i++) begin
      p.kind = i[0] ? KIND_CORRECT : KIND_PREDICT;
      p.is_wall = (i >= 12);
      p.pos_x = ext[i % 4];
      p.pos_y = ext[(i + 1) % 4];
      p.vel_x = ext[(i / 2) % 4];
      p.vel_y = ext[(i + 3) % 4];
      p.acc_x = ext[(i + 2) % 4];
      p.acc_y = ext[(i / 4) % 4];
      p.energy = (i % 3 == 0) ? 31'h7fffffff : (i % 3 == 1) ? 31'd0 : 31'd65536;
      p.energy_rate = ext[(i + 1) % 4];
      send_particle(p);
    end
  endtask

  task automatic test_random(int count, int idle, int stall);
    src_idle_pct = idle;
    sink_stall_pct = stall;
    for (int i = 0; i < count; i++) send_particle(rnd_particle());
    src_idle_pct = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(60, 0, 0);
    drain_and_set_dt(32'h0);
    test_directed();
    test_random(40, 52, 0);
    drain_and_set_dt(32'hffffffff);
    test_directed();
    test_random(60, 0, 52);
    drain_and_set_dt(32'h00008000);
    test_random(60, 12, 12);
    drain_and_set_dt(32'h00000001);
    test_random(40, 52, 0);
    drain_and_set_dt($urandom());
    test_random(60, 0, 0);
    drain_and_set_dt(32'h00010000);
    test_random(60, 12, 12);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d particles sent, %0d results checked", n_sent, n_got);
    $display("covered: predict/correct/wall, field extremes, seven time steps, idling");
    if (n_err == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
